// File: design/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Types, constants and bitsliced round functions for the 192-bit block
// cipher pipeline.
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam int BLOCK_W  = 192;
    localparam int WORD_W   = 32;
    localparam int NUM_COLS = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_MID  = 2'd1,
        CFG_KEY_LOW  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_mid;
        logic [63:0] plain_low;
    } t_plain;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_mid;
        logic [63:0] cipher_low;
    } t_cipher;

    // column c of the state, bit (31-r) holds block bit 6r+c
    typedef logic [NUM_COLS-1:0][WORD_W-1:0] t_cols;

    // round constants, one 192-bit value for each round but the last (word zero on the left)
    localparam logic [BLOCK_W-1:0] RCONST [8] = '{
        192'h243f6a88_85a308d3_13198a2e_03707344_a4093822_299f31d0,
        192'h082efa98_ec4e6c89_452821e6_38d01377_be5466cf_34e90c6c,
        192'hc0ac29b7_c97c50dd_3f84d5b5_b5470917_9216d5d9_8979fb1b,
        192'hd1310ba6_98dfb5ac_2ffd72db_d01adfb7_b8e1afed_6a267e96,
        192'hba7c9045_f12c7f99_24a19947_b3916cf7_0801f2e2_858efc16,
        192'h636920d8_71574e69_a458fea3_f4933d7e_0d95748f_728eb658,
        192'h718bcd58_82154aee_7b54a41d_c25a59b5_9c30d539_2af26013,
        192'hc5d1b023_286085f0_ca417918_b8db38ef_8e79dcb0_603a180e
    };

    localparam int MIX_ROT [6] = '{1, 5, 9, 15, 21, 26};

    // block bit p sits at vector index BLOCK_W-1-p
    function automatic t_cols to_cols(input logic [BLOCK_W-1:0] v);
        t_cols col;
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < WORD_W; r++) begin
                col[c][WORD_W-1-r] = v[BLOCK_W-1-(r*NUM_COLS+c)];
            end
        end
        return col;
    endfunction

    function automatic logic [BLOCK_W-1:0] from_cols(input t_cols col);
        logic [BLOCK_W-1:0] v;
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < WORD_W; r++) begin
                v[BLOCK_W-1-(r*NUM_COLS+c)] = col[c][WORD_W-1-r];
            end
        end
        return v;
    endfunction

    // next round key: bit p takes bit (7p+1) mod 192 of the previous key
    function automatic logic [BLOCK_W-1:0] key_perm(input logic [BLOCK_W-1:0] k);
        logic [BLOCK_W-1:0] nk;
        for (int p = 0; p < BLOCK_W; p++) begin
            nk[BLOCK_W-1-p] = k[BLOCK_W-1-((7*p+1) % BLOCK_W)];
        end
        return nk;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int t);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << t;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic t_cols sbox(input t_cols s);
        t_cols t;
        t[0] = (s[3] & ~s[5]) | (s[3] & s[4] & s[2]) | (~s[3] & s[1] & s[0])
             | (s[5] & s[4] & s[1]);
        t[1] = (s[5] & s[3] & ~s[2]) | (~s[5] & s[3] & ~s[4]) | (s[5] & s[2] & s[0])
             | (~s[3] & ~s[0] & s[1]);
        t[2] = (~s[3] & s[0] & s[4]) | (s[3] & s[0] & s[1]) | (~s[3] & ~s[4] & s[2])
             | (~s[0] & ~s[2] & ~s[5]);
        t[3] = (~s[0] & s[2] & ~s[3]) | (s[0] & s[2] & s[4]) | (s[0] & ~s[2] & s[5])
             | (~s[0] & s[3] & s[1]);
        t[4] = (s[0] & ~s[3]) | (s[0] & ~s[4] & ~s[2]) | (~s[0] & s[4] & s[5])
             | (~s[4] & ~s[2] & s[1]);
        t[5] = (s[2] & s[5]) | (~s[2] & ~s[1] & s[4]) | (s[2] & s[1] & s[0])
             | (~s[1] & s[0] & s[3]);
        return t;
    endfunction

    function automatic t_cols shift_cols(input t_cols s);
        t_cols t;
        for (int c = 0; c < NUM_COLS; c++) begin
            t[c] = rotl(s[c], c);
        end
        return t;
    endfunction

    function automatic t_cols mix_add(input t_cols s, input t_cols k);
        t_cols t;
        for (int c = 0; c < NUM_COLS; c++) begin
            t[c] = s[c] ^ k[c];
            for (int j = 0; j < 6; j++) begin
                t[c] = t[c] ^ rotl(s[c], MIX_ROT[j]);
            end
        end
        return t;
    endfunction

endpackage

// File: design/speedy_block_encrypt_unit.sv
// The start bit runs down the valid registers r_vld[0] to r_vld[ROUNDS] beside the data;
// o_valid is the last of them and is high for one cycle per accepted block.
// Throughput: one block per cycle; o_busy stays low, the pipeline never stalls.
// One register stage for the whitening key add, then one per round.
// Round keys are fixed wiring plus constant XOR off the three key registers.
// Synchronous active-low reset clears the valid bits and the key to zero.
// ----------------------------------------------------------------------------
// speedy_block_encrypt_unit
// Pipelined 192-bit block encryption under a 192-bit configurable key.
// ----------------------------------------------------------------------------
module speedy_block_encrypt_unit #(
    parameter int ROUNDS = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  sbe_pkg::t_plain                  i_plain,
    output logic                             o_valid,
    output sbe_pkg::t_cipher                 o_cipher,
    input  logic                             i_cfg_we,
    input  logic [sbe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [63:0] r_key_high, r_key_mid, r_key_low;

    logic [sbe_pkg::BLOCK_W-1:0] w_key [0:ROUNDS];
    sbe_pkg::t_cols              w_rk  [1:ROUNDS];
    sbe_pkg::t_cols              r_st  [0:ROUNDS];
    sbe_pkg::t_cols              n_st  [0:ROUNDS];
    logic                        r_vld [0:ROUNDS];

    assign o_busy = 1'b0;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_mid  <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbe_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                sbe_pkg::CFG_KEY_MID:  r_key_mid  <= i_cfg_data;
                sbe_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // key schedule: pure wiring, constants folded in
    assign w_key[0] = {r_key_high, r_key_mid, r_key_low};

    for (genvar r = 1; r <= ROUNDS; r++) begin : g_key
        assign w_key[r] = sbe_pkg::key_perm(w_key[r-1]);
        if (r < ROUNDS) begin : g_rc
            assign w_rk[r] = sbe_pkg::to_cols(w_key[r] ^ sbe_pkg::RCONST[r-1]);
        end else begin : g_last
            assign w_rk[r] = sbe_pkg::to_cols(w_key[r]);
        end
    end

    // whitening stage
    assign n_st[0] = sbe_pkg::to_cols(i_plain) ^ sbe_pkg::to_cols(w_key[0]);

    for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
        sbe_pkg::t_cols w_a;
        assign w_a = sbe_pkg::sbox(sbe_pkg::shift_cols(sbe_pkg::sbox(r_st[r-1])));
        if (r < ROUNDS) begin : g_full
            assign n_st[r] = sbe_pkg::mix_add(sbe_pkg::shift_cols(w_a), w_rk[r]);
        end else begin : g_final
            assign n_st[r] = w_a ^ w_rk[r];
        end
    end

    for (genvar s = 0; s <= ROUNDS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_st[s] <= n_st[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                if (s == 0) begin
                    r_vld[s] <= i_start;
                end else begin
                    r_vld[s] <= r_vld[(s == 0) ? 0 : s-1];
                end
            end
        end
    end

    assign o_valid  = r_vld[ROUNDS];
    assign o_cipher = sbe_pkg::from_cols(r_st[ROUNDS]);

endmodule

// File: design/sbe_checker.sv
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks on the encryption pipeline timing.
// ----------------------------------------------------------------------------
module sbe_checker #(
    parameter int ROUNDS = 7
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // the pipeline always takes a transaction
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    // every result traces back to a start a fixed latency earlier
    a_valid_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, ROUNDS + 1))
        else $error("result without matching start");

    // every accepted transaction comes out a fixed latency later
    a_start_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(ROUNDS + 1) o_valid)
        else $error("accepted transaction gave no result");

    // nothing comes out right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule

bind speedy_block_encrypt_unit sbe_checker #(.ROUNDS(ROUNDS)) u_sbe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
